// File: design/sdrs_pkg.sv
// ----------------------------------------------------------------------------
// SSTF disk request scheduler package
// Shared constants, codes and types of the scheduler.
// ----------------------------------------------------------------------------
package sdrs_pkg;

  localparam int unsigned QueueDepthDefault   = 16;
  localparam int unsigned CylinderBitsDefault = 14;

  localparam int unsigned CylW     = 14;
  localparam int unsigned SecW     = 8;
  localparam int unsigned LatW     = 28;
  localparam int unsigned XferW    = 16;
  localparam int unsigned TimeW    = 29;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 72;
  localparam int unsigned SumW     = 31;

  localparam logic [XferW-1:0] XferReset  = 16'd262;
  localparam logic [SumW-1:0]  SeekOffset = 31'd32768;
  localparam logic [SumW-1:0]  TimeMax    = 31'h1FFF_FFFF;
  localparam int unsigned      RootShift  = 30;

  localparam logic KindArrive   = 1'b0;
  localparam logic KindComplete = 1'b1;

  localparam logic [StatusW-1:0] StStarted  = 3'd0;
  localparam logic [StatusW-1:0] StQueued   = 3'd1;
  localparam logic [StatusW-1:0] StDropped  = 3'd2;
  localparam logic [StatusW-1:0] StIdle     = 3'd3;
  localparam logic [StatusW-1:0] StSpurious = 3'd4;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

// File: design/sdrs_cell.sv
// ----------------------------------------------------------------------------
// SSTF queue cell
// Holds one queued request; loads a new one or takes its neighbour's entry.
// ----------------------------------------------------------------------------
module sdrs_cell
  import sdrs_pkg::*;
#(
  parameter int unsigned CYL_W = CylinderBitsDefault
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [CYL_W-1:0] new_cyl_i,
  input  logic [SecW-1:0]  new_sec_i,
  input  logic [LatW-1:0]  new_lat_i,
  input  logic [CYL_W-1:0] nxt_cyl_i,
  input  logic [SecW-1:0]  nxt_sec_i,
  input  logic [LatW-1:0]  nxt_lat_i,
  output logic [CYL_W-1:0] cyl_o,
  output logic [SecW-1:0]  sec_o,
  output logic [LatW-1:0]  lat_o
);

  logic [CYL_W-1:0] cyl_q;
  logic [SecW-1:0]  sec_q;
  logic [LatW-1:0]  lat_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cyl_q <= new_cyl_i;
      sec_q <= new_sec_i;
      lat_q <= new_lat_i;
    end else if (ctrl_i.shift) begin
      cyl_q <= nxt_cyl_i;
      sec_q <= nxt_sec_i;
      lat_q <= nxt_lat_i;
    end
  end

  assign cyl_o = cyl_q;
  assign sec_o = sec_q;
  assign lat_o = lat_q;

endmodule

// File: design/sdrs_sqrt.sv
// ----------------------------------------------------------------------------
// SSTF seek square root
// Bit-serial integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module sdrs_sqrt
  import sdrs_pkg::*;
#(
  parameter int unsigned RAD_W = 44
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [RAD_W-1:0]     radicand_i,
  output logic                 done_o,
  output logic [RAD_W/2-1:0]   root_o
);

  logic [RAD_W-1:0] v_q, v_d;
  logic [RAD_W:0]   r_q, r_d;
  logic [RAD_W-1:0] bit_q, bit_d;
  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [RAD_W:0]   trial;

  always_comb begin
    trial  = r_q + {1'b0, bit_q};
    v_d    = v_q;
    r_d    = r_q;
    bit_d  = bit_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      v_d   = radicand_i;
      r_d   = '0;
      bit_d = {2'b01, {(RAD_W-2){1'b0}}};
      run_d = 1'b1;
    end else if (run_q) begin
      if ({1'b0, v_q} >= trial) begin
        v_d = RAD_W'({1'b0, v_q} - trial);
        r_d = (r_q >> 1) + {1'b0, bit_q};
      end else begin
        r_d = r_q >> 1;
      end
      bit_d = bit_q >> 2;
      if (bit_q[0]) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q   <= v_d;
    r_q   <= r_d;
    bit_q <= bit_d;
  end

  assign done_o = done_q;
  assign root_o = r_q[RAD_W/2-1:0];

endmodule

// File: design/sstf_disk_request_scheduler.sv
// ----------------------------------------------------------------------------
// SSTF disk request scheduler
// Shortest-seek-first scheduler with a shifting queue of request cells.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                 Payload
// s_axis   in         s_axis_tvalid/tready      tuser kind, tdata request
// m_axis   out        m_axis_tvalid/tready      tuser status, tdata result
// cfg      in         cfg_valid_i/cfg_ready_o   transfer time
//
// An arrival that queues or drops passes through the output state to its
// registered result. A start runs through launch, the bit-serial square root
// and the sum; a completion that picks from the queue runs the rotating scan
// and the removal shift before that. One transaction is in work at a time.
// Reset is asynchronous and needs no clearing pass. A stalled result holds the
// block in its output state until taken.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler
  import sdrs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = QueueDepthDefault,
  parameter int unsigned CYLINDER_BITS = CylinderBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // cylinder, sectors, rot_latency
  input  logic                s_axis_tuser,   // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // started_cylinder, started_sectors,
                                              // seek_distance, service_time
  output logic [StatusW-1:0]  m_axis_tuser,   // status
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [XferW-1:0]    cfg_data_i
);

  localparam int unsigned CB    = CYLINDER_BITS;
  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 2);
  localparam int unsigned RAD_W = 2 * ((CB + RootShift + 1) / 2);
  localparam int unsigned ROOT_W = RAD_W / 2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_REMOVE = 7'b0000100,
    S_LAUNCH = 7'b0001000,
    S_ROOT   = 7'b0010000,
    S_SUM    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  outst_q, outst_d;
  logic [CB-1:0]     head_q, head_d;
  logic [XferW-1:0]  xfer_q;
  logic [IDX_W-1:0]  scan_q, scan_d, best_q, best_d;
  logic [CB-1:0]     bestd_q, bestd_d;
  logic [CB-1:0]     wcyl_q, wcyl_d;
  logic [SecW-1:0]   wsec_q, wsec_d;
  logic [LatW-1:0]   wlat_q, wlat_d;
  logic [CB-1:0]     dist_q, dist_d;
  logic [SecW+XferW-1:0] prod_q, prod_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [StatusW-1:0] rstat_q, rstat_d;
  logic [TimeW-1:0]  rtime_q, rtime_d;
  logic              rstart_q, rstart_d;
  logic              ovalid_q;
  logic [OutDataW-1:0] odata_q;
  logic [StatusW-1:0]  ouser_q;

  logic              in_acc;
  logic [CB-1:0]     in_cyl;
  logic [SecW-1:0]   in_sec;
  logic [LatW-1:0]   in_lat;
  logic [CNT_W-1:0]  qcount;
  logic [CB-1:0]     scan_dist, launch_dist;
  logic              sq_start, sq_done;
  logic [ROOT_W-1:0] sq_root;
  logic [SumW-1:0]   seek, total;
  logic              load_slot;

  logic [CB-1:0]    cell_cyl [QUEUE_DEPTH];
  logic [SecW-1:0]  cell_sec [QUEUE_DEPTH];
  logic [LatW-1:0]  cell_lat [QUEUE_DEPTH];
  cell_ctrl_t       cell_ctrl [QUEUE_DEPTH];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_cyl        = CB'(s_axis_tdata[13:0]);
  assign in_sec        = s_axis_tdata[21:14];
  assign in_lat        = s_axis_tdata[49:22];
  assign qcount        = outst_q - CNT_W'(1);
  assign cfg_ready_o   = 1'b1;
  assign load_slot     = in_acc && (s_axis_tuser == KindArrive) && (outst_q != '0)
                         && (qcount < CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xfer_q <= XferReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      xfer_q <= cfg_data_i;
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam int unsigned NXT = (i + 1) % QUEUE_DEPTH;
    always_comb begin
      cell_ctrl[i].load  = load_slot && (qcount[IDX_W-1:0] == IDX_W'(i));
      cell_ctrl[i].shift = (state_q == S_SCAN) ||
                           ((state_q == S_REMOVE) && (IDX_W'(i) >= best_q));
    end
    sdrs_cell #(.CYL_W(CB)) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl[i]),
      .new_cyl_i (in_cyl),
      .new_sec_i (in_sec),
      .new_lat_i (in_lat),
      .nxt_cyl_i (cell_cyl[NXT]),
      .nxt_sec_i (cell_sec[NXT]),
      .nxt_lat_i (cell_lat[NXT]),
      .cyl_o     (cell_cyl[i]),
      .sec_o     (cell_sec[i]),
      .lat_o     (cell_lat[i])
    );
  end

  assign sq_start = (state_q == S_LAUNCH);

  sdrs_sqrt #(.RAD_W(RAD_W)) u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (RAD_W'(launch_dist) << RootShift),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  always_comb begin
    scan_dist   = (head_q > cell_cyl[0]) ? head_q - cell_cyl[0] : cell_cyl[0] - head_q;
    launch_dist = (head_q > wcyl_q) ? head_q - wcyl_q : wcyl_q - head_q;
    seek        = (dist_q != '0) ? SeekOffset + SumW'(root_q) : '0;
    total       = seek + SumW'(wlat_q) + SumW'(prod_q);
  end

  always_comb begin
    state_d  = state_q;
    outst_d  = outst_q;
    head_d   = head_q;
    scan_d   = scan_q;
    best_d   = best_q;
    bestd_d  = bestd_q;
    wcyl_d   = wcyl_q;
    wsec_d   = wsec_q;
    wlat_d   = wlat_q;
    dist_d   = dist_q;
    prod_d   = prod_q;
    root_d   = root_q;
    rstat_d  = rstat_q;
    rtime_d  = rtime_q;
    rstart_d = rstart_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          rstart_d = 1'b0;
          state_d  = S_OUT;
          if (s_axis_tuser == KindArrive) begin
            if (outst_q == '0) begin
              wcyl_d  = in_cyl;
              wsec_d  = in_sec;
              wlat_d  = in_lat;
              outst_d = CNT_W'(1);
              state_d = S_LAUNCH;
            end else if (load_slot) begin
              outst_d = outst_q + CNT_W'(1);
              rstat_d = StQueued;
            end else begin
              rstat_d = StDropped;
            end
          end else begin
            if (outst_q == '0) begin
              rstat_d = StSpurious;
            end else if (outst_q == CNT_W'(1)) begin
              outst_d = '0;
              rstat_d = StIdle;
            end else begin
              scan_d  = '0;
              state_d = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if ((CNT_W'(scan_q) < qcount) && ((scan_q == '0) || (scan_dist < bestd_q))) begin
          best_d  = scan_q;
          bestd_d = scan_dist;
          wcyl_d  = cell_cyl[0];
          wsec_d  = cell_sec[0];
          wlat_d  = cell_lat[0];
        end
        scan_d = scan_q + IDX_W'(1);
        if (scan_q == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_d = S_REMOVE;
        end
      end
      S_REMOVE: begin
        outst_d = outst_q - CNT_W'(1);
        state_d = S_LAUNCH;
      end
      S_LAUNCH: begin
        dist_d  = launch_dist;
        head_d  = wcyl_q;
        prod_d  = wsec_q * xfer_q;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (sq_done) begin
          root_d  = sq_root;
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        rtime_d  = (total > TimeMax) ? TimeMax[TimeW-1:0] : total[TimeW-1:0];
        rstat_d  = StStarted;
        rstart_d = 1'b1;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (!ovalid_q || m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      outst_q  <= '0;
      head_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      outst_q <= outst_d;
      head_q  <= head_d;
      if ((state_q == S_OUT) && (!ovalid_q || m_axis_tready)) begin
        ovalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    best_q   <= best_d;
    bestd_q  <= bestd_d;
    wcyl_q   <= wcyl_d;
    wsec_q   <= wsec_d;
    wlat_q   <= wlat_d;
    dist_q   <= dist_d;
    prod_q   <= prod_d;
    root_q   <= root_d;
    rstat_q  <= rstat_d;
    rtime_q  <= rtime_d;
    rstart_q <= rstart_d;
    if ((state_q == S_OUT) && (!ovalid_q || m_axis_tready)) begin
      ouser_q <= rstat_q;
      if (rstart_q) begin
        odata_q <= {7'd0, rtime_q, 14'(dist_q), wsec_q, 14'(wcyl_q)};
      end else begin
        odata_q <= '0;
      end
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  a_outst_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q <= CNT_W'(QUEUE_DEPTH + 1)) else $error("outstanding count overflow");

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");

  a_scan_has_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (outst_q >= CNT_W'(2))) else $error("scan with empty queue");

  a_root_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> (state_q == S_ROOT)) else $error("root result outside root state");

endmodule

// File: verif/sstf_disk_request_scheduler_tb.sv
// ----------------------------------------------------------------------------
// SSTF disk request scheduler testbench
// Drives arrivals, completions and transfer-time writes through the block,
// predicts each result with a shortest-seek queue model and compares it whole.
// ----------------------------------------------------------------------------
module sstf_disk_request_scheduler_tb;
  import sdrs_pkg::*;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [CylW-1:0]    cyl;
    logic [SecW-1:0]    sec;
    logic [CylW-1:0]    seek_dist;
    logic [TimeW-1:0]   svc;
  } sched_result_t;

  class seek_scoreboard;
    logic [XferW-1:0] xfer;
    int unsigned      busy;
    logic [CylW-1:0]  head;
    logic [CylW-1:0]  q_cyl[$];
    logic [SecW-1:0]  q_sec[$];
    logic [LatW-1:0]  q_lat[$];
    sched_result_t    pending[$];
    int unsigned      errors;

    function new();
      xfer = XferReset;
      busy = 0;
      head = '0;
      errors = 0;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function automatic sched_result_t launch(logic [CylW-1:0] c, logic [SecW-1:0] s,
                                             logic [LatW-1:0] l);
      sched_result_t   r;
      longint unsigned d, sk, tot;
      d = (head > c) ? head - c : c - head;
      sk = (d != 0) ? 64'd32768 + isqrt(d << 30) : 0;
      tot = sk + l + s * xfer;
      if (tot > 64'h1FFF_FFFF) tot = 64'h1FFF_FFFF;
      head = c;
      r.status = StStarted;
      r.cyl = c;
      r.sec = s;
      r.seek_dist = d[CylW-1:0];
      r.svc = tot[TimeW-1:0];
      return r;
    endfunction

    function void note_request(logic kind, logic [CylW-1:0] c, logic [SecW-1:0] s,
                               logic [LatW-1:0] l);
      sched_result_t r;
      int            best;
      int unsigned   bd, d;
      r = '0;
      if (kind == KindArrive) begin
        if (busy == 0) begin
          r = launch(c, s, l);
          busy = 1;
        end else if (busy - 1 < QueueDepthDefault) begin
          q_cyl.push_back(c);
          q_sec.push_back(s);
          q_lat.push_back(l);
          busy++;
          r.status = StQueued;
        end else begin
          r.status = StDropped;
        end
      end else if (busy == 0) begin
        r.status = StSpurious;
      end else if (busy == 1) begin
        busy = 0;
        r.status = StIdle;
      end else begin
        best = 0;
        bd = (head > q_cyl[0]) ? head - q_cyl[0] : q_cyl[0] - head;
        for (int i = 1; i < q_cyl.size(); i++) begin
          d = (head > q_cyl[i]) ? head - q_cyl[i] : q_cyl[i] - head;
          if (d < bd) begin
            bd = d;
            best = i;
          end
        end
        r = launch(q_cyl[best], q_sec[best], q_lat[best]);
        q_cyl.delete(best);
        q_sec.delete(best);
        q_lat.delete(best);
        busy--;
      end
      pending.push_back(r);
    endfunction

    function void check_result(sched_result_t act);
      sched_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result %p", act);
        return;
      end
      exp = pending.pop_front();
      if (exp !== act) begin
        errors++;
        if (errors <= 10) $display("Mismatch: expected %p, actual %p", exp, act);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;   // cylinder, sectors, rot_latency
  logic                s_axis_tuser = 1'b0; // kind
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // started_cylinder, started_sectors,
                                            // seek_distance, service_time
  logic [StatusW-1:0]  m_axis_tuser;        // status
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [XferW-1:0]    cfg_data_i = '0;

  seek_scoreboard sb = new();
  int unsigned    cycle_count = 0;
  bit             hold_off = 1'b0;

  sstf_disk_request_scheduler dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 2_000_000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_result({m_axis_tuser, m_axis_tdata[CylW-1:0],
                       m_axis_tdata[CylW+SecW-1:CylW],
                       m_axis_tdata[2*CylW+SecW-1:CylW+SecW],
                       m_axis_tdata[2*CylW+SecW+TimeW-1:2*CylW+SecW]});
    end
  end

  // The receiver stalls in a pattern of its own, with calm stretches.
  initial begin
    int unsigned mode;
    mode = 0;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 99) == 0) mode = $urandom_range(0, 2);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (mode == 0) m_axis_tready <= 1'b1;
      else if (mode == 1) m_axis_tready <= ($urandom_range(0, 3) != 0);
      else m_axis_tready <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_request(logic kind, logic [CylW-1:0] c, logic [SecW-1:0] s,
                              logic [LatW-1:0] l);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {{(InDataW-CylW-SecW-LatW){1'b0}}, l, s, c};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(kind, c, s, l);
  endtask

  task automatic pause_sender(int unsigned n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_xfer(logic [XferW-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.xfer = v;
  endtask

  task automatic random_phase(int unsigned n);
    int unsigned burst, hot;
    logic        kind;
    logic [CylW-1:0] c;
    hot = $urandom_range(0, 16383);
    burst = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      kind = ($urandom_range(0, 99) < 45) ? KindComplete : KindArrive;
      case ($urandom_range(0, 3))
        0: c = CylW'($urandom_range(0, 16383));
        1: c = CylW'(hot + $urandom_range(0, 8));
        2: c = ($urandom_range(0, 1) != 0) ? 14'h3FFF : 14'h0;
        default: c = CylW'(sb.head + $urandom_range(0, 4) - 2);
      endcase
      send_request(kind, c, SecW'($urandom_range(0, 255)),
                   ($urandom_range(0, 9) == 0) ? 28'hFFF_FFFF
                                               : LatW'($urandom_range(0, 28'hFFF_FFFF)));
      if (--burst == 0) begin
        if ($urandom_range(0, 1) != 0) pause_sender($urandom_range(1, 30));
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(KindComplete, 0, 0, 0);
    send_request(KindArrive, 0, 0, 0);
    send_request(KindArrive, 14'h3FFF, 8'hFF, 28'hFFF_FFFF);
    send_request(KindArrive, 100, 1, 5);
    send_request(KindArrive, 100, 2, 6);
    send_request(KindArrive, 14'h2AAA, 8'h55, 28'hAAA_AAAA);
    send_request(KindComplete, 0, 0, 0);
    send_request(KindComplete, 0, 0, 0);
    send_request(KindComplete, 0, 0, 0);
    send_request(KindComplete, 0, 0, 0);
    send_request(KindComplete, 0, 0, 0);
    send_request(KindComplete, 0, 0, 0);
    for (int i = 0; i < 18; i++) begin
      send_request(KindArrive, CylW'(14'h1555 + i), SecW'(i), LatW'(i));
    end
    drain_results();

    // The receiver holds off while random arrivals and completions meet the full queue.
    write_xfer(16'hFFFF);
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(40);
    join
    for (int i = 0; i < 20; i++) send_request(KindComplete, 0, 0, 0);
    drain_results();

    write_xfer(16'h0000);
    random_phase(500);
    drain_results();
    write_xfer(XferW'($urandom_range(0, 65535)));
    random_phase(600);
    drain_results();
    write_xfer(XferReset);
    random_phase(500);
    drain_results();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sstf_disk_request_scheduler.f
design/sdrs_pkg.sv
design/sdrs_cell.sv
design/sdrs_sqrt.sv
design/sstf_disk_request_scheduler.sv
verif/sstf_disk_request_scheduler_tb.sv
